### hdl/clws_pkg.sv
// Shared types, constants and the init byte table for the character LCD sequencer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package clws_pkg;

  // Field and register widths
  localparam int TICK_W      = 20;
  localparam int SHORT_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [SHORT_W-1:0] STROBE_RESET = 16'd50;
  localparam logic [SHORT_W-1:0] HOLD_RESET   = 16'd50;
  localparam logic [TICK_W-1:0]  POWER_RESET  = 20'd35000;
  localparam logic [SHORT_W-1:0] SHORT_RESET  = 16'd50;
  localparam logic [SHORT_W-1:0] CLEAR_RESET  = 16'd2000;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_STROBE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR  = 3'd4;

  // Init sequence: last step is entry mode set, preceded by display clear
  localparam logic [1:0] INIT_LAST = 2'd3;

  // Input mode codes
  typedef enum logic [1:0] {
    OP_INSTR = 2'd0,
    OP_DATA  = 2'd1,
    OP_INIT  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // Sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_STROBE = 5'b00010,
    PH_HOLD   = 5'b00100,
    PH_POWER  = 5'b01000,
    PH_PAUSE  = 5'b10000
  } phase_t;

  // Classified command as it travels through the queue
  typedef struct packed {
    logic       tick;
    logic       init;
    logic       sel;
    logic [7:0] value;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic       sel;
    logic       en;
    logic [7:0] value;
    logic       busy;
    logic       rej;
  } res_t;

  // Init instruction bytes: function set, display on, clear, entry mode
  function automatic logic [7:0] init_byte(input logic [1:0] step);
    logic [7:0] b;
    case (step)
      2'd0:    b = 8'h38;
      2'd1:    b = 8'h0C;
      2'd2:    b = 8'h01;
      2'd3:    b = 8'h06;
      default: b = 8'h38;
    endcase
    return b;
  endfunction

endpackage

### hdl/clws_front.sv
// Front end: accepts input items and classifies the mode into a queue command.
// Depends on clws_pkg.
`timescale 1ns / 1ps

module clws_front
  import clws_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] byte_value,
  input  logic       queue_full,
  output logic       push,
  output cmd_t       cmd
);

  // Stall while the queue has no room
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Classify the mode
  always_comb begin
    cmd.tick  = 1'b0;
    cmd.init  = 1'b0;
    cmd.sel   = 1'b0;
    cmd.value = byte_value;
    case (op_t'(mode))
      OP_INSTR: cmd.sel  = 1'b0;
      OP_DATA:  cmd.sel  = 1'b1;
      OP_INIT:  cmd.init = 1'b1;
      OP_TICK:  cmd.tick = 1'b1;
      default:  cmd.tick = 1'b0;
    endcase
  end

endmodule

### hdl/clws_queue.sv
// Short command queue between front and back ends.
// Depends on clws_pkg.
`timescale 1ns / 1ps

module clws_queue
  import clws_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/clws_back.sv
// Back end: timing registers, write/init sequencer and the result register.
// Depends on clws_pkg.
`timescale 1ns / 1ps

module clws_back
  import clws_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   not_empty,
  input  cmd_t                   head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output res_t                   res
);

  logic [SHORT_W-1:0] strobe_ticks;
  logic [SHORT_W-1:0] hold_ticks;
  logic [TICK_W-1:0]  power_on_ticks;
  logic [SHORT_W-1:0] short_pause_ticks;
  logic [SHORT_W-1:0] clear_pause_ticks;

  phase_t            phase, phase_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [7:0]        latched_byte, latched_byte_next;
  logic              latched_select, latched_select_next;
  logic [1:0]        init_step, init_step_next;
  logic              in_init, in_init_next;
  logic              rej_next;

  logic [TICK_W-1:0]  tc_inc;
  logic [1:0]         step_inc;
  logic [SHORT_W-1:0] pause_cur;
  logic [SHORT_W-1:0] pause_after;
  logic               busy;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_ticks      <= STROBE_RESET;
      hold_ticks        <= HOLD_RESET;
      power_on_ticks    <= POWER_RESET;
      short_pause_ticks <= SHORT_RESET;
      clear_pause_ticks <= CLEAR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STROBE: strobe_ticks      <= cfg_data[SHORT_W-1:0];
        REG_HOLD:   hold_ticks        <= cfg_data[SHORT_W-1:0];
        REG_POWER:  power_on_ticks    <= cfg_data[TICK_W-1:0];
        REG_SHORT:  short_pause_ticks <= cfg_data[SHORT_W-1:0];
        REG_CLEAR:  clear_pause_ticks <= cfg_data[SHORT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Take the next command when the result register is free
  assign pop = not_empty && (!out_valid || !out_stall);

  assign tc_inc      = tick_count + 1'b1;
  assign step_inc    = init_step + 1'b1;
  assign pause_cur   = (init_step == INIT_LAST) ? clear_pause_ticks : short_pause_ticks;
  assign pause_after = (step_inc == INIT_LAST) ? clear_pause_ticks : short_pause_ticks;
  assign busy        = (phase inside {PH_STROBE, PH_HOLD, PH_POWER, PH_PAUSE});

  // Sequencer step for one command
  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    latched_byte_next   = latched_byte;
    latched_select_next = latched_select;
    init_step_next      = init_step;
    in_init_next        = in_init;
    rej_next            = 1'b0;
    if (head.tick) begin
      case (phase)
        PH_IDLE: ;
        PH_STROBE: begin
          tick_count_next = tc_inc;
          if (tc_inc >= TICK_W'(strobe_ticks)) begin
            phase_next      = PH_HOLD;
            tick_count_next = '0;
          end
        end
        PH_HOLD: begin
          tick_count_next = tc_inc;
          if (tc_inc >= TICK_W'(hold_ticks)) begin
            tick_count_next = '0;
            if (!in_init || init_step == INIT_LAST) begin
              phase_next     = PH_IDLE;
              in_init_next   = 1'b0;
              init_step_next = '0;
            end else begin
              init_step_next = step_inc;
              if (pause_after == '0) begin
                phase_next          = PH_STROBE;
                latched_select_next = 1'b0;
                latched_byte_next   = init_byte(step_inc);
              end else begin
                phase_next = PH_PAUSE;
              end
            end
          end
        end
        PH_POWER: begin
          tick_count_next = tc_inc;
          if (tc_inc >= power_on_ticks) begin
            phase_next          = PH_STROBE;
            tick_count_next     = '0;
            latched_select_next = 1'b0;
            latched_byte_next   = init_byte(init_step);
          end
        end
        PH_PAUSE: begin
          tick_count_next = tc_inc;
          if (tc_inc >= TICK_W'(pause_cur)) begin
            phase_next          = PH_STROBE;
            tick_count_next     = '0;
            latched_select_next = 1'b0;
            latched_byte_next   = init_byte(init_step);
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end else if (busy) begin
      rej_next = 1'b1;
    end else if (head.init) begin
      in_init_next    = 1'b1;
      init_step_next  = '0;
      phase_next      = PH_POWER;
      tick_count_next = '0;
    end else begin
      in_init_next        = 1'b0;
      latched_select_next = head.sel;
      latched_byte_next   = head.value;
      phase_next          = PH_STROBE;
      tick_count_next     = '0;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      latched_byte   <= '0;
      latched_select <= 1'b0;
      init_step      <= '0;
      in_init        <= 1'b0;
    end else if (pop) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      latched_byte   <= latched_byte_next;
      latched_select <= latched_select_next;
      init_step      <= init_step_next;
      in_init        <= in_init_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, held while stalled
  always_ff @(posedge clk) begin
    if (pop) begin
      res.sel   <= latched_select_next;
      res.en    <= (phase_next == PH_STROBE);
      res.value <= latched_byte_next;
      res.busy  <= (phase_next != PH_IDLE);
      res.rej   <= rej_next;
    end
  end

endmodule

### hdl/char_lcd_write_sequencer_top.sv
// Top level of the character LCD write sequencer: front end, command queue, back end.
// Depends on clws_pkg, clws_front, clws_queue and clws_back.
`timescale 1ns / 1ps

// Drives an 8-bit parallel character LCD from a stream of items (instruction
// write, data write, start init, tick). Every item gives exactly one result
// with the RS, R/W, E and D0-D7 levels after the item, plus busy and
// rejected. One item is accepted per clock when the queue has room; each
// item passes through the command queue and then the result register
// before its result appears. The sequencer step for each item is
// combinational, so a steady stream of items with no output stall runs at
// one item per clock. Timing registers are written through the cfg port and
// take effect for the next item.

module char_lcd_write_sequencer_top
  import clws_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             mode,
  input  logic [7:0]             byte_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   reg_select,
  output logic                   read_not_write,
  output logic                   enable_pin,
  output logic [7:0]             data_bus,
  output logic                   busy_res,
  output logic                   rejected
);

  logic queue_full;
  logic push;
  logic pop;
  logic not_empty;
  cmd_t push_cmd;
  cmd_t head;
  res_t res;

  clws_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .byte_value (byte_value),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  clws_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  clws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Drive the pins from the result register
  assign reg_select     = res.sel;
  assign read_not_write = 1'b0;
  assign enable_pin     = res.en;
  assign data_bus       = res.value;
  assign busy_res       = res.busy;
  assign rejected       = res.rej;

endmodule

### hdl/clws_checker.sv
// Port-level checks for the character LCD write sequencer, bound to the top level.
// Depends on clws_pkg and char_lcd_write_sequencer_top.
`timescale 1ns / 1ps

module clws_port_checks
  import clws_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       enable_pin,
  input logic [7:0] data_bus,
  input logic       busy_res,
  input logic       rejected
);

  // A strobe only happens while a write is in progress
  assert property (@(posedge clk) disable iff (rst)
    out_valid && enable_pin |-> busy_res)
    else $error("enable high while not busy");

  // A rejected command leaves the block busy
  assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res)
    else $error("rejected while idle");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_bus) && $stable(busy_res))
    else $error("stalled result changed");

  // No result right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind char_lcd_write_sequencer_top clws_port_checks u_clws_port_checks (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .enable_pin (enable_pin),
  .data_bus   (data_bus),
  .busy_res   (busy_res),
  .rejected   (rejected)
);
